[src/cmpp_pkg.sv]
`default_nettype none
package cmpp_pkg;
  localparam int FracBits = 16;
  localparam int ValW = FracBits + 2;
  localparam int CordicSteps = 16;
  localparam int TabLen = 24;
  localparam int StepW = 5;
  localparam logic signed [ValW-1:0] Tenth = ValW'(((1 << FracBits) + 5) / 10);
  localparam logic signed [33:0] KQ30 = 34'sh026DD3B6A;
  localparam logic [31:0] PiQ30 = 32'hC90FDAA2;
  localparam int CfgW = 13;

  function automatic logic signed [33:0] atan_q30(input logic [StepW-1:0] i);
    case (i)
      5'd0: atan_q30 = 34'sh03243F6A8;
      5'd1: atan_q30 = 34'sh01DAC6705;
      5'd2: atan_q30 = 34'sh00FADBAFC;
      5'd3: atan_q30 = 34'sh007F56EA6;
      5'd4: atan_q30 = 34'sh003FEAB76;
      5'd5: atan_q30 = 34'sh001FFD55B;
      5'd6: atan_q30 = 34'sh000FFFAAA;
      5'd7: atan_q30 = 34'sh0007FFF55;
      5'd8: atan_q30 = 34'sh0003FFFEA;
      5'd9: atan_q30 = 34'sh0001FFFFD;
      5'd10: atan_q30 = 34'sh0000FFFFF;
      5'd11: atan_q30 = 34'sh00007FFFF;
      5'd12: atan_q30 = 34'sh00003FFFF;
      5'd13: atan_q30 = 34'sh00001FFFF;
      5'd14: atan_q30 = 34'sh00000FFFF;
      5'd15: atan_q30 = 34'sh000007FFF;
      5'd16: atan_q30 = 34'sh000003FFF;
      5'd17: atan_q30 = 34'sh000001FFF;
      5'd18: atan_q30 = 34'sh000000FFF;
      5'd19: atan_q30 = 34'sh0000007FF;
      5'd20: atan_q30 = 34'sh0000003FF;
      5'd21: atan_q30 = 34'sh0000001FF;
      5'd22: atan_q30 = 34'sh0000000FF;
      5'd23: atan_q30 = 34'sh00000007F;
      default: atan_q30 = '0;
    endcase
  endfunction

  typedef struct packed {
    logic restart;
    logic [17:0] phase_gain;
    logic [16:0] mix_weight;
    logic signed [15:0] sin_theta;
    logic signed [15:0] cos_theta;
    logic signed [15:0] sin_phi;
    logic signed [15:0] cos_phi;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic saturated;
  } out_beat_t;
endpackage
`default_nettype wire

[src/cmpp_if.sv]
`default_nettype none
interface cmpp_in_if;
  logic valid;
  logic ready;
  logic restart;
  logic [17:0] phase_gain;
  logic [16:0] mix_weight;
  logic signed [15:0] sin_theta;
  logic signed [15:0] cos_theta;
  logic signed [15:0] sin_phi;
  logic signed [15:0] cos_phi;
  modport source(output valid, restart, phase_gain, mix_weight, sin_theta, cos_theta,
                 sin_phi, cos_phi, input ready);
  modport sink(input valid, restart, phase_gain, mix_weight, sin_theta, cos_theta,
               sin_phi, cos_phi, output ready);
endinterface

interface cmpp_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] x_pos;
  logic signed [15:0] y_pos;
  logic saturated;
  modport source(output valid, x_pos, y_pos, saturated, input ready);
  modport sink(input valid, x_pos, y_pos, saturated, output ready);
endinterface
`default_nettype wire

[src/cmpp_cordic.sv]
`default_nettype none
// Rotation-mode CORDIC cosine, one micro-rotation per cycle.
module cmpp_cordic (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic signed [33:0]  angle,
  output logic                     done,
  output logic signed [33:0]       cos_out
);
  logic signed [33:0] x, y, z;
  logic [cmpp_pkg::StepW-1:0] i;
  logic busy;
  logic signed [33:0] xs, ys;

  assign xs = x >>> i;
  assign ys = y >>> i;
  assign cos_out = x;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      x <= cmpp_pkg::KQ30;
      y <= '0;
      z <= angle;
      i <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      if (!z[33]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - cmpp_pkg::atan_q30(i);
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + cmpp_pkg::atan_q30(i);
      end
      i <= i + 1'b1;
      if (i == cmpp_pkg::StepW'(cmpp_pkg::CordicSteps - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without run");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done) else $error("done while busy");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> i < cmpp_pkg::StepW'(cmpp_pkg::CordicSteps)) else $error("step overrun");
endmodule
`default_nettype wire

[src/chaotic_map_point_projector_core.sv]
`default_nettype none
// Channel   Dir  Beat
// in_ch     in   restart, phase_gain, mix_weight, view sines/cosines
// out_ch    out  x_pos, y_pos, saturated
// apb       in   screen_width (0x0), screen_height (0x4)
//
// One beat runs from accept to the next accept: PHASE, FOLD and RAD for the
// phase, CORD for the CORDIC (16 steps plus start and hand-off), MIXA to MIXC
// for the mix, PRJ, ACC and SCALE once per axis for the projection, OUTW to
// load the output register (it waits while that register is full), then IDLE.
// Each point depends on the previous one, so in_ch.ready is high only in IDLE.
// rst (sync) reloads map values with 0.1 and screen size with 640x480.
// A result waits in the output register while the next point is computed;
// that point then waits in OUTW until the output register frees up.
module chaotic_map_point_projector_core (
  input  wire logic        clk,
  input  wire logic        rst,
  cmpp_in_if.sink          in_ch,
  cmpp_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int VW = cmpp_pkg::ValW;
  typedef enum logic [3:0] {
    IDLE, PHASE, FOLD, RAD, CORD, MIXA, MIXB, MIXC,
    PRJ, ACC, SCALE, OUTW
  } state_t;

  state_t state;
  logic [12:0] screen_width, screen_height;
  logic signed [VW-1:0] value_newest, value_previous, value_oldest;
  cmpp_pkg::in_beat_t item;
  logic sat;
  logic signed [15:0] x_res, y_res;

  // shared multiplier
  logic signed [35:0] ma, mb;
  logic signed [71:0] mp;
  logic signed [71:0] prod;
  assign mp = ma * mb;

  logic signed [71:0] acc;
  logic signed [63:0] cs;
  logic [3:0] k;
  logic [34:0] u30;
  logic neg;
  logic cstart, cdone;
  logic signed [33:0] cang, cos_q30;

  cmpp_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cstart), .angle(cang),
    .done(cdone), .cos_out(cos_q30)
  );

  // APB
  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      1'b0: prdata = {19'd0, screen_width};
      default: prdata = {19'd0, screen_height};
    endcase
  end

  assign in_ch.ready = (state == IDLE);

  // phase folding on product a*p (32 fraction bits, half-turns)
  logic [32:0] uw, uf;
  logic fneg;
  always_comb begin
    uw = prod[32:0];
    if (uw > 33'h100000000) uw = 33'h200000000 - uw;
    fneg = 1'b0;
    uf = uw;
    if (uw > 33'h080000000) begin
      uf = 33'h100000000 - uw;
      fneg = 1'b1;
    end
  end

  // projection helpers: half * |sum| in two 32-bit halves, then >> 44
  logic [11:0] half;
  logic [63:0] mag;
  logic [43:0] plo;
  logic [47:0] qsum;
  logic [35:0] q;
  assign mag = acc[71] ? 64'(-acc) : 64'(acc);
  assign qsum = 48'(mp) + 48'(plo[43:32]);
  assign q = 36'(qsum >> 12);

  logic signed [71:0] nv_full;
  logic signed [71:0] rnd;
  assign rnd = acc + (72'sd1 << 29);
  assign nv_full = rnd >>> 30;

  logic signed [15:0] res;
  logic cl;
  always_comb begin
    cl = 1'b0;
    if (acc[71]) begin
      if (q > 36'd32768) begin res = -16'sd32768; cl = 1'b1; end
      else res = 16'(-$signed({1'b0, q[15:0]}));
    end else begin
      if (q > 36'd32767) begin res = 16'sd32767; cl = 1'b1; end
      else res = 16'(q);
    end
  end

  // sequencer operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      PHASE: begin ma = 36'($signed({1'b0, item.phase_gain})); mb = 36'(value_previous); end
      RAD:   begin ma = 36'($signed({1'b0, u30})); mb = 36'($signed({1'b0, cmpp_pkg::PiQ30})); end
      MIXA:  begin ma = 36'(18'sd65536 - $signed({1'b0, item.mix_weight})); mb = 36'(cs); end
      MIXB:  begin ma = 36'($signed({1'b0, item.mix_weight})); mb = 36'(value_oldest) <<< 14; end
      PRJ: begin
        case (k)
          4'd0: begin ma = 36'(item.sin_theta); mb = 36'(value_previous); end
          4'd1: begin ma = 36'(item.cos_theta); mb = 36'(item.cos_phi); end
          4'd2: begin ma = 36'(prod); mb = 36'(value_newest); end
          4'd3: begin ma = 36'(item.cos_theta); mb = 36'(item.sin_phi); end
          4'd4: begin ma = 36'(prod); mb = 36'(value_oldest); end
          4'd5: begin ma = 36'(item.cos_theta); mb = 36'(value_previous); end
          4'd6: begin ma = 36'(item.sin_theta); mb = 36'(item.cos_phi); end
          4'd7: begin ma = 36'(prod); mb = 36'(value_newest); end
          4'd8: begin ma = 36'(item.sin_theta); mb = 36'(item.sin_phi); end
          default: begin ma = 36'(prod); mb = 36'(value_oldest); end
        endcase
      end
      ACC:   begin ma = 36'($signed({1'b0, half})); mb = 36'($signed({1'b0, mag[31:0]})); end
      SCALE: begin ma = 36'($signed({1'b0, half})); mb = 36'($signed({1'b0, mag[63:32]})); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    cstart <= 1'b0;
    if (rst) begin
      state <= IDLE;
      screen_width <= 13'd640;
      screen_height <= 13'd480;
      value_newest <= cmpp_pkg::Tenth;
      value_previous <= cmpp_pkg::Tenth;
      value_oldest <= cmpp_pkg::Tenth;
      out_ch.valid <= 1'b0;
      cstart <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr == 3'd0) screen_width <= pwdata[12:0];
        else if (paddr == 3'd4) screen_height <= pwdata[12:0];
      end
      if (out_ch.valid && out_ch.ready && state != OUTW) out_ch.valid <= 1'b0;
      case (state)
        IDLE: if (in_ch.valid) begin
          item <= '{in_ch.restart, in_ch.phase_gain, in_ch.mix_weight, in_ch.sin_theta,
                    in_ch.cos_theta, in_ch.sin_phi, in_ch.cos_phi};
          if (in_ch.restart) begin
            value_newest <= cmpp_pkg::Tenth;
            value_previous <= cmpp_pkg::Tenth;
            value_oldest <= cmpp_pkg::Tenth;
          end
          sat <= 1'b0;
          state <= PHASE;
        end
        PHASE: begin prod <= mp; state <= FOLD; end
        FOLD: begin u30 <= 35'(uf >> 2); neg <= fneg; state <= RAD; end
        RAD: begin
          cang <= 34'(mp >>> 30);
          cstart <= 1'b1;
          state <= CORD;
        end
        CORD: if (cdone) begin
          cs <= neg ? -64'(cos_q30) : 64'(cos_q30);
          state <= MIXA;
        end
        MIXA: begin acc <= mp; state <= MIXB; end
        MIXB: begin acc <= acc + mp; state <= MIXC; end
        MIXC: begin
          value_oldest <= value_previous;
          value_previous <= value_newest;
          if (nv_full > 72'sd131071) begin value_newest <= 18'sd131071; sat <= 1'b1; end
          else if (nv_full < -72'sd131072) begin value_newest <= -18'sd131072; sat <= 1'b1; end
          else value_newest <= VW'(nv_full);
          acc <= 72'sd1 <<< 44;
          k <= '0;
          state <= PRJ;
        end
        PRJ: begin
          prod <= mp;
          case (k)
            4'd0: acc <= acc + (mp <<< 14);
            4'd2: acc <= acc + mp;
            4'd4: acc <= acc - mp;
            4'd5: acc <= acc - (mp <<< 14);
            4'd7: acc <= acc + mp;
            4'd9: acc <= acc - mp;
            default: ;
          endcase
          if (k == 4'd4) begin
            half <= screen_width[12:1];
            state <= ACC;
          end else if (k == 4'd9) begin
            half <= screen_height[12:1];
            state <= ACC;
          end
          k <= k + 1'b1;
        end
        // low half of half*|sum|; the high half is formed in SCALE
        ACC: begin
          plo <= 44'(mp);
          state <= SCALE;
        end
        SCALE: begin
          if (k == 4'd5) begin
            x_res <= res;
            sat <= sat | cl;
            acc <= 72'sd1 <<< 44;
            state <= PRJ;
          end else begin
            y_res <= res;
            sat <= sat | cl;
            state <= OUTW;
          end
        end
        OUTW: if (!out_ch.valid || out_ch.ready) begin
          out_ch.valid <= 1'b1;
          out_ch.x_pos <= x_res;
          out_ch.y_pos <= y_res;
          out_ch.saturated <= sat;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_valid_from_outw: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(state == OUTW)) else $error("spurious result");
  a_cordic_start: assert property (@(posedge clk) disable iff (rst)
    cstart |-> state == CORD) else $error("cordic start misplaced");
endmodule
`default_nettype wire
